// File: rtl/core/isc_pkg.sv
// Package for the streaming infix calculator.
// Holds the sequencer state type, operator codes and ASCII constants.
// No dependencies.
package isc_pkg;

  // Sequencer states of the shared arithmetic unit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV,
    ST_DIV_FIX,
    ST_POST
  } state_t;

  // Multiplicative operator waiting for the number being read.
  typedef enum logic [1:0] {
    POP_NONE,
    POP_MUL,
    POP_DIV
  } pop_t;

  // Operator character that started the current close of a number.
  typedef enum logic [2:0] {
    OPK_MUL,
    OPK_DIV,
    OPK_ADD,
    OPK_SUB,
    OPK_EQ
  } opk_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

// File: rtl/core/infix_calculator_stream_top.sv
// Streaming infix calculator: one ASCII character per input word, one
// result word per '='. Depends on isc_pkg.
//
// Usage:
//   Input channel (ch, in_valid, in_stall) takes one character per word.
//   Digits build a number, + - * / are operators with the usual two levels
//   of precedence, '=' closes the expression, anything else is ignored.
//   Output channel (value, div_zero, out_valid, out_stall) carries one
//   word per '=': the wrapped signed result and a division-by-zero flag.
// Sequencing:
//   A digit or an ignored character is taken while idle. An operator or '='
//   with no pending * or / goes through ST_POST; with a pending * it first
//   runs ST_MUL (one shift-add step per cycle); with a pending / and a nonzero
//   divisor it runs ST_DIV_A, ST_DIV_B, ST_DIV (one restoring step per cycle)
//   and ST_DIV_FIX for sign handling. All steps share one adder/subtractor.
//   The block holds in_stall high while it works on a character.
// Reset: rst clears the expression state and drops out_valid.
// Stall: a result waits in the output register while out_stall is high;
//   characters are still taken, and a following '=' waits until the
//   register is free.
module infix_calculator_stream_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               in_valid,
  output logic               in_stall,
  output logic signed [31:0] value,
  output logic               div_zero,
  output logic               out_valid,
  input  logic               out_stall
);
  import isc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  // Expression state.
  logic [DW-1:0] sum_acc;
  logic [DW-1:0] term_acc;
  logic [DW-1:0] number_acc;
  logic          additive_op;
  pop_t          pending_op;
  logic          error_seen;

  // Working registers of the sequencer.
  state_t        state;
  state_t        state_next;
  opk_t          opk;
  logic [DW-1:0] opa;
  logic [DW-1:0] opb;
  logic [DW-1:0] work;
  logic [DW-2:0] rem;
  logic [CW-1:0] cnt;
  logic          q_neg;

  // Shared adder/subtractor.
  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_b;
  logic          alu_sub;
  logic [DW:0]   alu_full;
  logic [DW-1:0] alu_y;
  logic          alu_c;

  logic          in_take;
  logic          is_digit;
  logic          is_op;
  opk_t          in_kind;
  logic [DW-1:0] num_dec;
  logic [DW-1:0] rem_shift;
  logic          out_free;
  logic          cnt_done;
  logic          res_load;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cnt_done = (cnt == '0);
  assign res_load = (state == ST_POST) && (opk == OPK_EQ) && out_free;

  // Character decode.
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign num_dec  = {number_acc[DW-4:0], 3'b000} + {number_acc[DW-2:0], 1'b0}
                  + DW'(ch - CH_ZERO);

  always_comb begin
    is_op   = 1'b1;
    in_kind = OPK_EQ;
    unique case (ch)
      CH_STAR:  in_kind = OPK_MUL;
      CH_SLASH: in_kind = OPK_DIV;
      CH_PLUS:  in_kind = OPK_ADD;
      CH_MINUS: in_kind = OPK_SUB;
      CH_EQUAL: in_kind = OPK_EQ;
      default:  is_op   = 1'b0;
    endcase
  end

  // Restoring division: partial remainder shifted by one dividend bit.
  assign rem_shift = {rem, opa[DW-1]};

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_MUL: begin
        alu_a = work;
        alu_b = opa;
      end
      ST_DIV_A: begin
        alu_b   = term_acc;
        alu_sub = 1'b1;
      end
      ST_DIV_B: begin
        alu_b   = number_acc;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = rem_shift;
        alu_b   = opb;
        alu_sub = 1'b1;
      end
      ST_DIV_FIX: begin
        alu_b   = opa;
        alu_sub = 1'b1;
      end
      ST_POST: begin
        alu_a   = sum_acc;
        alu_b   = term_acc;
        alu_sub = additive_op;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_full = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (DW+1)'(alu_sub);
  assign alu_y    = alu_full[DW-1:0];
  assign alu_c    = alu_full[DW];

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && is_op) begin
          priority if (pending_op == POP_MUL) begin
            state_next = ST_MUL;
          end else if (pending_op == POP_DIV && number_acc != '0) begin
            state_next = ST_DIV_A;
          end else begin
            state_next = ST_POST;
          end
        end
      end
      ST_MUL:     if (cnt_done) state_next = ST_POST;
      ST_DIV_A:   state_next = ST_DIV_B;
      ST_DIV_B:   state_next = ST_DIV;
      ST_DIV:     if (cnt_done) state_next = ST_DIV_FIX;
      ST_DIV_FIX: state_next = ST_POST;
      ST_POST: begin
        if (opk != OPK_EQ || out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, updated per sequencer step.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc     <= '0;
      term_acc    <= '0;
      number_acc  <= '0;
      additive_op <= 1'b0;
      pending_op  <= POP_NONE;
      error_seen  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // The output register fills on a result and empties when its word is taken.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take && is_digit) begin
            number_acc <= num_dec;
          end else if (in_take && is_op) begin
            opk <= in_kind;
            priority if (pending_op == POP_MUL) begin
              work <= '0;
              opa  <= term_acc;
              opb  <= number_acc;
              cnt  <= CW'(DW - 1);
            end else if (pending_op == POP_DIV) begin
              if (number_acc == '0) begin
                term_acc   <= '0;
                error_seen <= 1'b1;
              end
              q_neg <= term_acc[DW-1] ^ number_acc[DW-1];
            end else begin
              term_acc <= number_acc;
            end
          end
        end
        ST_MUL: begin
          if (opb[0]) begin
            work <= alu_y;
          end
          opa <= {opa[DW-2:0], 1'b0};
          opb <= {1'b0, opb[DW-1:1]};
          cnt <= cnt - CW'(1);
          if (cnt_done) begin
            term_acc <= opb[0] ? alu_y : work;
          end
        end
        ST_DIV_A: begin
          opa <= term_acc[DW-1] ? alu_y : term_acc;
        end
        ST_DIV_B: begin
          opb <= number_acc[DW-1] ? alu_y : number_acc;
          rem <= '0;
          cnt <= CW'(DW - 1);
        end
        ST_DIV: begin
          // Carry out of the subtract means the shifted remainder >= divisor.
          rem <= alu_c ? alu_y[DW-2:0] : rem_shift[DW-2:0];
          opa <= {opa[DW-2:0], alu_c};
          cnt <= cnt - CW'(1);
        end
        ST_DIV_FIX: begin
          term_acc <= q_neg ? alu_y : opa;
        end
        ST_POST: begin
          unique case (opk)
            OPK_MUL: begin
              pending_op <= POP_MUL;
              number_acc <= '0;
            end
            OPK_DIV: begin
              pending_op <= POP_DIV;
              number_acc <= '0;
            end
            OPK_ADD, OPK_SUB: begin
              sum_acc     <= alu_y;
              term_acc    <= '0;
              number_acc  <= '0;
              pending_op  <= POP_NONE;
              additive_op <= (opk == OPK_SUB);
            end
            OPK_EQ: begin
              // Result goes out once the output register is free.
              if (out_free) begin
                value       <= 32'($signed(alu_y));
                div_zero    <= error_seen;
                sum_acc     <= '0;
                term_acc    <= '0;
                number_acc  <= '0;
                additive_op <= 1'b0;
                pending_op  <= POP_NONE;
                error_seen  <= 1'b0;
              end
            end
            default: begin
              pending_op <= POP_NONE;
            end
          endcase
        end
        default: begin
          number_acc <= number_acc;
        end
      endcase
    end
  end

endmodule

// File: tb/infix_calculator_stream_top_tb.sv
// Testbench for the streaming infix calculator: drives character words, predicts
// each '=' result with its own expression evaluator and checks the output words.
// Depends on isc_pkg and infix_calculator_stream_top.
module infix_calculator_stream_top_tb;
  import isc_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RAND_CHARS = 900;
  localparam int LONG_HOLD = 300;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 80;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [31:0] value;
    logic        div_zero;
  } calc_result_t;

  // Tells digits, operators and '=' apart from characters the block skips.
  function automatic bit is_active(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH || c == CH_EQUAL;
  endfunction

  // Evaluates the character stream and holds the results still to arrive.
  class calc_scoreboard;
    logic [31:0]  sum_acc;
    logic [31:0]  term_acc;
    logic [31:0]  number_acc;
    logic         minus_pending;
    pop_t         mul_op;
    logic         div_err;
    calc_result_t expected_q[$];
    int           errors;
    int           results_seen;
    int           div_zero_seen;

    function new();
      clear_expr();
      errors = 0;
      results_seen = 0;
      div_zero_seen = 0;
    endfunction

    function void clear_expr();
      sum_acc = '0;
      term_acc = '0;
      number_acc = '0;
      minus_pending = 1'b0;
      mul_op = POP_NONE;
      div_err = 1'b0;
    endfunction

    // Signed division that truncates toward zero; the zero divisor is handled by the caller.
    function logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      if (mb == '0) return '0;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    // Folds the number being read into the pending product term.
    function void close_operand();
      case (mul_op)
        POP_MUL: term_acc = term_acc * number_acc;
        POP_DIV: begin
          if (number_acc == '0) begin
            term_acc = '0;
            div_err = 1'b1;
          end else begin
            term_acc = sdiv32(term_acc, number_acc);
          end
        end
        default: term_acc = number_acc;
      endcase
      number_acc = '0;
    endfunction

    function logic [31:0] sum_with_term();
      return minus_pending ? sum_acc - term_acc : sum_acc + term_acc;
    endfunction

    // Advances the evaluator by one accepted character word.
    function void note_char(logic [7:0] c);
      calc_result_t r;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        number_acc = number_acc * 10 + 32'(c - CH_ZERO);
      end else if (c == CH_STAR || c == CH_SLASH) begin
        close_operand();
        if (c == CH_STAR) mul_op = POP_MUL;
        else mul_op = POP_DIV;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        close_operand();
        sum_acc = sum_with_term();
        term_acc = '0;
        mul_op = POP_NONE;
        minus_pending = (c == CH_MINUS);
      end else if (c == CH_EQUAL) begin
        close_operand();
        r.value = sum_with_term();
        r.div_zero = div_err;
        expected_q.push_back(r);
        clear_expr();
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compares one output word with the oldest predicted result.
    task check_result(logic [31:0] value, logic div_zero);
      calc_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h/%b with nothing expected", value, div_zero));
        return;
      end
      exp_r = expected_q.pop_front();
      results_seen++;
      if (exp_r.div_zero) div_zero_seen++;
      if (value !== exp_r.value)
        report($sformatf("value got %h expected %h", value, exp_r.value));
      if (div_zero !== exp_r.div_zero)
        report($sformatf("div_zero got %b expected %b", div_zero, exp_r.div_zero));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [7:0]         ch = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] value;
  logic               div_zero;
  logic               out_valid;
  logic               out_stall = 1'b0;

  calc_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_asks = 0;
  int hold_served = 0;
  int chars_sent = 0;
  int active_chars = 0;

  infix_calculator_stream_top #(.DATA_WIDTH(32)) dut (
    .clk(clk),
    .rst(rst),
    .ch(ch),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .div_zero(div_zero),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle lengths: mostly short, now and then long, none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [7:0] ignored_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_active(c));
    return c;
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Mostly small numbers, some wide ones and the values around the wrap points.
  function automatic string random_number();
    logic [63:0] n;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) n = 64'($urandom_range(0, 99));
    else if (sel < 75) n = 64'($urandom_range(0, 99999));
    else if (sel < 85) n = {$urandom, $urandom} % 64'd10000000000;
    else begin
      case ($urandom_range(0, 6))
        0: n = 64'd0;
        1: n = 64'd1;
        2: n = 64'd2147483647;
        3: n = 64'd2147483648;
        4: n = 64'd4294967295;
        5: n = 64'd4294967289;
        default: n = 64'd9999999999;
      endcase
    end
    return $sformatf("%0d", n);
  endfunction

  // Offers one character word and waits until the block takes it.
  task automatic send_char(logic [7:0] c);
    int gap;
    ch <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
    chars_sent++;
    if (is_active(c)) active_chars++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Builds one expression: mostly well formed, sometimes broken or pure noise.
  task automatic send_random_expr();
    char_q_t q;
    string num;
    int nterms;
    logic [7:0] op;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(3, 8)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      nterms = $urandom_range(1, 5);
      op = CH_PLUS;
      for (int t = 0; t < nterms; t++) begin
        if (t > 0) begin
          op = random_op();
          q.push_back(op);
          if ($urandom_range(0, 99) < 5) q.push_back(random_op());
        end
        if ($urandom_range(0, 99) < 4) num = "";
        else if (op == CH_SLASH && $urandom_range(0, 99) < 20) num = "0";
        else num = random_number();
        for (int i = 0; i < num.len(); i++) begin
          q.push_back(num[i]);
          if ($urandom_range(0, 99) < 4) q.push_back(ignored_char());
        end
        if ($urandom_range(0, 99) < 6) q.push_back(ignored_char());
      end
      if ($urandom_range(0, 99) < 92) q.push_back(CH_EQUAL);
    end
    foreach (q[i]) send_char(q[i]);
  endtask

  // Output side: checks accepted result words and drives random stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(value, div_zero);
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        stall_left = pick_stall_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed expressions, random expressions, drain.
  initial begin
    int target;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty expression, missing number, division by zero, skipped bytes inside a number.
    send_text("=");
    send_text("3+=");
    send_text("9/0=");
    send_char(8'h31);
    send_char(8'hFF);
    send_text("2-7*3");
    send_char(8'h00);
    send_text("/2=");
    in_valid <= 1'b0;
    wait_results();

    target = active_chars + RAND_CHARS;
    while (active_chars < target) begin
      if ($urandom_range(0, 99) < 8) calm = !calm;
      // Long output hold while characters keep coming, so the input backs up.
      if (!held && active_chars > target - (2 * RAND_CHARS) / 3) begin
        held = 1'b1;
        calm = 1'b0;
        hold_asks++;
      end
      // Sender pause until every outstanding result has come back.
      if (!paused && active_chars > target - RAND_CHARS / 3) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait_results();
      end
      send_random_expr();
    end
    send_char(CH_EQUAL);
    in_valid <= 1'b0;
    calm = 1'b0;

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d characters (%0d digits/operators), %0d results, %0d with div_zero.",
             chars_sent, active_chars, sb.results_seen, sb.div_zero_seen);
    $display("Mismatches: %0d; long output holds: %0d.", sb.errors, hold_served);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timeout with %0d results still expected.", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/isc_pkg.sv
rtl/core/infix_calculator_stream_top.sv
tb/infix_calculator_stream_top_tb.sv
